>>> hw/rtl/canwl_pkg.sv
// Shared types, constants and helpers for the CAN identifier filter and rate limiter.
package canwl_pkg;

  localparam int unsigned IdSpace = 2048;
  localparam int unsigned IdW     = 11;
  localparam int unsigned LenW    = 4;
  localparam int unsigned DataW   = 64;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned IntW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [IntW-1:0] MinIntervalRst = 16'd200;
  localparam logic            FwdEnableRst   = 1'b1;
  localparam logic [LenW-1:0] MaxLen         = 4'd8;

  typedef enum logic [0:0] {
    KIND_FRAME = 1'b0,
    KIND_TABLE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    VERD_FWD      = 3'd0,
    VERD_DENY     = 3'd1,
    VERD_RATE     = 3'd2,
    VERD_TABLE    = 3'd3,
    VERD_DISABLED = 3'd4
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_INTERVAL = 1'b0,
    CFG_FWD_ENABLE   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [TimeW-1:0] now;
    logic             allow;
    logic             prio;
  } item_t;

  typedef struct packed {
    logic [IntW-1:0] min_interval;
    logic            fwd_enable;
  } cfg_t;

  function automatic logic is_prio(logic [IdW-1:0] id);
    logic hit;
    hit = 1'b0;
    case (id)
      11'h257, 11'h266, 11'h2E5, 11'h33A,
      11'h292, 11'h311, 11'h3F5, 11'h249: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // len is already clamped to eight
  function automatic logic [DataW-1:0] byte_mask(logic [LenW-1:0] len);
    logic [DataW-1:0] mask;
    mask = '0;
    for (int b = 0; b < DataW / 8; b++) begin
      mask[8*b +: 8] = (len > LenW'(b)) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

>>> hw/rtl/canwl_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module canwl_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [canwl_pkg::IdW-1:0]   frame_id_i,
  input  logic [canwl_pkg::LenW-1:0]  length_code_i,
  input  logic [canwl_pkg::DataW-1:0] payload_i,
  input  logic [canwl_pkg::TimeW-1:0] now_ms_i,
  input  logic                        allow_bit_i,
  input  logic                        busy_i,
  output logic                        q_valid_o,
  output canwl_pkg::item_t            q_item_o,
  input  logic                        q_pop_i
);
  import canwl_pkg::*;

  item_t       fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  item_t       cls;
  logic [LenW-1:0] len_c;
  logic        push;

  always_comb begin
    len_c     = (length_code_i > MaxLen) ? MaxLen : length_code_i;
    cls.kind  = kind_e'(kind_i);
    cls.id    = frame_id_i;
    cls.len   = len_c;
    cls.data  = payload_i & byte_mask(len_c);
    cls.now   = now_ms_i;
    cls.allow = allow_bit_i;
    cls.prio  = is_prio(frame_id_i);
  end

  assign in_ready_o = (count_q != 2'd2) && !busy_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !q_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

>>> hw/rtl/canwl_back.sv
// Back end: per-identifier table lookup, decision, table update and result register.
module canwl_back #(
  parameter int unsigned IdSpace = canwl_pkg::IdSpace
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  canwl_pkg::cfg_t             cfg_i,
  input  logic                        q_valid_i,
  input  canwl_pkg::item_t            q_item_i,
  output logic                        q_pop_o,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  verdict_o,
  output logic [canwl_pkg::IdW-1:0]   out_id_o,
  output logic [canwl_pkg::LenW-1:0]  out_length_o,
  output logic [canwl_pkg::DataW-1:0] out_payload_o,
  output logic [canwl_pkg::TimeW-1:0] out_time_o
);
  import canwl_pkg::*;

  localparam int unsigned AddrW = $clog2(IdSpace);
  localparam int unsigned EntW  = TimeW + 1;

  // entry: allow bit on top, last send time below
  logic [EntW-1:0]  mem_q [IdSpace];
  logic [EntW-1:0]  rd_q;
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             exec_q;
  item_t            item_q;
  logic             byp_q;
  logic [EntW-1:0]  byp_data_q;
  logic             out_valid_q;
  verdict_e         verdict_q, verdict_d;
  logic [IdW-1:0]   id_q;
  logic [LenW-1:0]  len_q, len_d;
  logic [DataW-1:0] data_q, data_d;
  logic [TimeW-1:0] time_q, time_d;

  logic [EntW-1:0]  eff;
  logic [TimeW-1:0] diff;
  logic             rate_ok;
  logic             fire;
  logic             pop;
  logic             wr;
  logic [EntW-1:0]  wdata;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [EntW-1:0]  mem_wdata;

  assign fire    = exec_q && (!out_valid_q || out_ready_i);
  assign pop     = q_valid_i && !clr_busy_q && (!exec_q || fire);
  assign q_pop_o = pop;
  assign busy_o  = clr_busy_q;

  assign eff     = byp_q ? byp_data_q : rd_q;
  assign diff    = item_q.now - eff[TimeW-1:0];
  assign rate_ok = item_q.prio || (diff >= TimeW'(cfg_i.min_interval));

  always_comb begin
    verdict_d = VERD_DENY;
    len_d     = '0;
    data_d    = '0;
    time_d    = '0;
    wr        = 1'b0;
    wdata     = eff;
    if (item_q.kind == KIND_TABLE) begin
      verdict_d = VERD_TABLE;
      wr        = 1'b1;
      wdata     = {item_q.allow, eff[TimeW-1:0]};
    end else if (!eff[TimeW]) begin
      verdict_d = VERD_DENY;
    end else if (!rate_ok) begin
      verdict_d = VERD_RATE;
    end else begin
      verdict_d = cfg_i.fwd_enable ? VERD_FWD : VERD_DISABLED;
      len_d     = item_q.len;
      data_d    = item_q.data;
      time_d    = item_q.now;
      wr        = 1'b1;
      wdata     = {1'b1, item_q.now};
    end
  end

  always_comb begin
    mem_we    = clr_busy_q || (fire && wr);
    mem_waddr = clr_busy_q ? clr_cnt_q : item_q.id[AddrW-1:0];
    mem_wdata = clr_busy_q ? '0 : wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      rd_q <= mem_q[q_item_i.id[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      exec_q      <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(IdSpace - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (pop) begin
        exec_q <= 1'b1;
        byp_q  <= fire && wr && (item_q.id == q_item_i.id);
      end else if (fire) begin
        exec_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q     <= q_item_i;
      byp_data_q <= wdata;
    end
    if (fire) begin
      verdict_q <= verdict_d;
      id_q      <= item_q.id;
      len_q     <= len_d;
      data_q    <= data_d;
      time_q    <= time_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign out_id_o      = id_q;
  assign out_length_o  = len_q;
  assign out_payload_o = data_q;
  assign out_time_o    = time_q;

endmodule

>>> hw/rtl/can_id_whitelist_rate_limiter.sv
// Top level of the CAN identifier allow filter and per-identifier rate limiter.
// Input channel (in_valid_i/in_ready_o): either a received frame (kind 0) or an
// allow-map write (kind 1). Output channel (out_valid_o/out_ready_i): one result
// per input transfer, in order, with its verdict and the forwarded frame fields.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 sets the minimum
// interval in ms, index 1 the forward enable; always ready.
// Throughput: one item per cycle while the receiver does not stall; the registered
// table read of one item overlaps the table write of the previous one, with a
// bypass when both hit the same id. An input passes through the two-entry queue,
// the back end's item register and the result register.
// Reset: the allow map and last send times are swept to zero, one entry per
// cycle over all IdSpace entries; in_ready_o stays low during the sweep.
// When the receiver stalls, the result register holds, the back end stops and
// the two-entry queue fills; then in_ready_o drops.
module can_id_whitelist_rate_limiter #(
  parameter int unsigned IdSpace = canwl_pkg::IdSpace
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [canwl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [canwl_pkg::IntW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [canwl_pkg::IdW-1:0]     frame_id_i,
  input  logic [canwl_pkg::LenW-1:0]    length_code_i,
  input  logic [canwl_pkg::DataW-1:0]   payload_i,
  input  logic [canwl_pkg::TimeW-1:0]   now_ms_i,
  input  logic                          allow_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    verdict_o,
  output logic [canwl_pkg::IdW-1:0]     out_id_o,
  output logic [canwl_pkg::LenW-1:0]    out_length_o,
  output logic [canwl_pkg::DataW-1:0]   out_payload_o,
  output logic [canwl_pkg::TimeW-1:0]   out_time_o
);
  import canwl_pkg::*;

  cfg_t  cfg_q;
  logic  busy;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_interval <= MinIntervalRst;
      cfg_q.fwd_enable   <= FwdEnableRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_INTERVAL: cfg_q.min_interval <= cfg_data_i;
        CFG_FWD_ENABLE:   cfg_q.fwd_enable   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  canwl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .frame_id_i    (frame_id_i),
    .length_code_i (length_code_i),
    .payload_i     (payload_i),
    .now_ms_i      (now_ms_i),
    .allow_bit_i   (allow_bit_i),
    .busy_i        (busy),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  canwl_back #(
    .IdSpace (IdSpace)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .verdict_o     (verdict_o),
    .out_id_o      (out_id_o),
    .out_length_o  (out_length_o),
    .out_payload_o (out_payload_o),
    .out_time_o    (out_time_o)
  );

endmodule

>>> tb/tb.sv
// Testbench for the CAN identifier allow filter and rate limiter: shadow model and checks.
`timescale 1ns / 100ps

module tb;
  import canwl_pkg::*;

  typedef struct {
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [TimeW-1:0] now;
    logic             allow;
  } rx_item_t;

  typedef struct {
    verdict_e         verdict;
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [DataW-1:0] data;
    logic [TimeW-1:0] stamp;
  } filter_result_t;

  class filter_shadow;
    bit                allow_map [IdSpace];
    bit [TimeW-1:0]    last_sent [IdSpace];
    logic [IdW-1:0]    prio_ids [8];
    logic [IntW-1:0]   min_interval;
    bit                fwd_enable;
    filter_result_t    due_results [$];
    int unsigned       verdict_hits [5];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      prio_ids     = '{11'h257, 11'h266, 11'h2E5, 11'h33A, 11'h292, 11'h311, 11'h3F5, 11'h249};
      min_interval = MinIntervalRst;
      fwd_enable   = FwdEnableRst;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [IntW-1:0] val);
      if (idx == CFG_MIN_INTERVAL) min_interval = val;
      else fwd_enable = val[0];
    endfunction

    function void note_transfer(rx_item_t it);
      filter_result_t r;
      logic [LenW-1:0] n;
      logic [TimeW-1:0] gap;
      bit fast;
      r.verdict = VERD_FWD;
      r.id      = it.id;
      r.len     = '0;
      r.data    = '0;
      r.stamp   = '0;
      fast      = 1'b0;
      foreach (prio_ids[i]) if (prio_ids[i] == it.id) fast = 1'b1;
      if (it.kind == KIND_TABLE) begin
        allow_map[it.id] = it.allow;
        r.verdict = VERD_TABLE;
      end else if (!allow_map[it.id]) begin
        r.verdict = VERD_DENY;
      end else begin
        gap = it.now - last_sent[it.id];
        if (!fast && gap < {16'd0, min_interval}) begin
          r.verdict = VERD_RATE;
        end else begin
          n = (it.len > 4'd8) ? 4'd8 : it.len;
          last_sent[it.id] = it.now;
          r.verdict = fwd_enable ? VERD_FWD : VERD_DISABLED;
          r.len     = n;
          r.stamp   = it.now;
          for (int b = 0; b < 8; b++) if (b < n) r.data[8*b +: 8] = it.data[8*b +: 8];
        end
      end
      verdict_hits[r.verdict]++;
      due_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("MISMATCH %s", what);
    endtask

    task check_result(filter_result_t got);
      filter_result_t exp;
      checked++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result id %h verdict %0d with nothing pending",
                                  got.id, got.verdict));
      end else begin
        exp = due_results.pop_front();
        if (got.verdict !== exp.verdict || got.id !== exp.id || got.len !== exp.len ||
            got.data !== exp.data || got.stamp !== exp.stamp)
          report_mismatch($sformatf(
            "id %h/%h verdict %0d/%0d len %0d/%0d data %h/%h time %h/%h (got/exp)",
            got.id, exp.id, got.verdict, exp.verdict, got.len, exp.len,
            got.data, exp.data, got.stamp, exp.stamp));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [IntW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [IdW-1:0]      frame_id_i;
  logic [LenW-1:0]     length_code_i;
  logic [DataW-1:0]    payload_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                allow_bit_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [2:0]          verdict_o;
  logic [IdW-1:0]      out_id_o;
  logic [LenW-1:0]     out_length_o;
  logic [DataW-1:0]    out_payload_o;
  logic [TimeW-1:0]    out_time_o;

  filter_shadow        sb;
  filter_result_t      seen_result;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  logic [TimeW-1:0]    tick_ms;
  logic [IdW-1:0]      pool [16];

  can_id_whitelist_rate_limiter dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .frame_id_i    (frame_id_i),
    .length_code_i (length_code_i),
    .payload_i     (payload_i),
    .now_ms_i      (now_ms_i),
    .allow_bit_i   (allow_bit_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .verdict_o     (verdict_o),
    .out_id_o      (out_id_o),
    .out_length_o  (out_length_o),
    .out_payload_o (out_payload_o),
    .out_time_o    (out_time_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.verdict = verdict_e'(verdict_o);
      seen_result.id      = out_id_o;
      seen_result.len     = out_length_o;
      seen_result.data    = out_payload_o;
      seen_result.stamp   = out_time_o;
      sb.check_result(seen_result);
    end
  end

  function automatic rx_item_t mk(kind_e kind, logic [IdW-1:0] id, logic [LenW-1:0] len,
                                  logic [DataW-1:0] data, logic [TimeW-1:0] now,
                                  logic allow);
    rx_item_t it;
    it.kind  = kind;
    it.id    = id;
    it.len   = len;
    it.data  = data;
    it.now   = now;
    it.allow = allow;
    return it;
  endfunction

  // mostly frames to the allowed pool on a running clock near the interval
  function automatic rx_item_t draw_item();
    rx_item_t it;
    int unsigned r;
    r        = $urandom_range(99);
    it.kind  = KIND_FRAME;
    it.len   = LenW'($urandom_range(15));
    it.data  = {$urandom, $urandom};
    it.allow = 1'($urandom_range(1));
    it.id    = pool[$urandom_range(15)];
    it.now   = tick_ms;
    if (r < 10) begin
      it.kind  = KIND_TABLE;
      if (r < 3) it.id = IdW'($urandom_range(2047));
      it.allow = ($urandom_range(9) < 8);
    end else if (r < 18) begin
      it.id  = IdW'($urandom_range(2047));
      it.now = $urandom;
    end else if (r < 22) begin
      it.now = $urandom;
    end else begin
      tick_ms = tick_ms + $urandom_range(sb.min_interval / 8 + 2);
    end
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_item(input rx_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    frame_id_i    <= it.id;
    length_code_i <= it.len;
    payload_i     <= it.data;
    now_ms_i      <= it.now;
    allow_bit_i   <= it.allow;
    do @(posedge clk); while (!in_ready_o);
    sb.note_transfer(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [IntW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain(input int unsigned limit);
    int unsigned n;
    n = 0;
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
  endtask

  initial begin
    int unsigned min_sel [6];
    bit          fwd_sel [6];
    int unsigned idle_sel [6];
    int unsigned stall_sel [6];
    sb             = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_MIN_INTERVAL;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_FRAME;
    frame_id_i     = '0;
    length_code_i  = '0;
    payload_i      = '0;
    now_ms_i       = '0;
    allow_bit_i    = 1'b0;
    out_ready_i    = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tick_ms        = '0;
    min_sel        = '{200, 0, 65535, 1000, 0, 200};
    min_sel[4]     = $urandom_range(1, 65534);
    fwd_sel        = '{1, 1, 0, 1, 0, 1};
    idle_sel       = '{0, 46, 0, 9, 46, 0};
    stall_sel      = '{0, 0, 46, 9, 0, 46};
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);

    // directed: fresh-reset timing, length clamp, wrap, priority bypass
    push_item(mk(KIND_FRAME, 11'h123, 4'd8, '1, 32'd1000, 1'b1));
    push_item(mk(KIND_TABLE, 11'h123, 4'd0, '0, 32'd0, 1'b1));
    push_item(mk(KIND_FRAME, 11'h123, 4'd2, '1, 32'd50, 1'b0));
    push_item(mk(KIND_FRAME, 11'h123, 4'd3, '1, 32'd200, 1'b0));
    push_item(mk(KIND_FRAME, 11'h123, 4'd8, '1, 32'd399, 1'b0));
    push_item(mk(KIND_FRAME, 11'h123, 4'd0, '1, 32'd400, 1'b0));
    push_item(mk(KIND_TABLE, 11'h257, 4'd15, '1, '1, 1'b1));
    push_item(mk(KIND_FRAME, 11'h257, 4'd15, '1, 32'd0, 1'b0));
    push_item(mk(KIND_FRAME, 11'h257, 4'd9, 64'hA5A5_5A5A_0F0F_F0F0, 32'd1, 1'b1));
    push_item(mk(KIND_TABLE, 11'h7FF, 4'd0, '0, 32'd0, 1'b1));
    push_item(mk(KIND_TABLE, 11'h000, 4'd0, '0, 32'd0, 1'b1));
    push_item(mk(KIND_FRAME, 11'h7FF, 4'd8, {$urandom, $urandom}, '1, 1'b0));
    push_item(mk(KIND_FRAME, 11'h7FF, 4'd8, '1, 32'd5, 1'b0));
    push_item(mk(KIND_FRAME, 11'h7FF, 4'd1, '1, 32'd199, 1'b0));
    push_item(mk(KIND_FRAME, 11'h000, 4'd8, '1, 32'd0, 1'b0));
    push_item(mk(KIND_FRAME, 11'h000, 4'd7, '1, '1, 1'b0));
    push_item(mk(KIND_TABLE, 11'h123, 4'd0, '0, 32'd0, 1'b0));
    push_item(mk(KIND_FRAME, 11'h123, 4'd8, '1, 32'd5000, 1'b1));

    for (int p = 0; p < 6; p++) begin
      drain(20000);
      write_reg(CFG_MIN_INTERVAL, IntW'(min_sel[p]));
      write_reg(CFG_FWD_ENABLE, IntW'(fwd_sel[p]));
      send_idle_pct  = idle_sel[p];
      recv_stall_pct = stall_sel[p];
      tick_ms        = (p == 3) ? 32'hFFFF_0000 : $urandom;
      foreach (sb.prio_ids[i]) pool[i] = sb.prio_ids[i];
      pool[8] = 11'h7FF;
      pool[9] = 11'h000;
      for (int i = 10; i < 16; i++) pool[i] = IdW'($urandom_range(2047));
      foreach (pool[i]) push_item(mk(KIND_TABLE, pool[i], '0, '0, '0, 1'b1));
      for (int n = 0; n < 300; n++) begin
        if (p == 1 && n == 150) drain(20000);
        push_item(draw_item());
      end
    end

    drain(20000);
    repeat (8) @(negedge clk);
    if (sb.due_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.due_results.size()));
    $display("run: %0d results checked over 6 register settings (interval 0 to 65535)",
             sb.checked);
    $display("run: forwarded %0d, denied %0d, rate limited %0d, table %0d, disabled %0d",
             sb.verdict_hits[VERD_FWD], sb.verdict_hits[VERD_DENY],
             sb.verdict_hits[VERD_RATE], sb.verdict_hits[VERD_TABLE],
             sb.verdict_hits[VERD_DISABLED]);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
